### src/wmh_pkg.sv
// ----------------------------------------------------------------------------
// wmh_pkg
// shared types, constants and helper functions of the word mix hash engine
// ----------------------------------------------------------------------------
package wmh_pkg;

    localparam int WORD_W    = 64;
    localparam int HALF_W    = WORD_W / 2;
    localparam int LEN_W     = 32;
    localparam int COUNT_W   = 4;
    localparam int BYTES     = WORD_W / 8;

    localparam logic [WORD_W-1:0] HASH_K1 = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] HASH_K2 = 64'h6c62272e07bb0142;
    localparam logic [WORD_W-1:0] HASH_K3 = 64'h94d049bb133111eb;

    localparam int ROT_AMT     = 27;
    localparam int FIN_SHIFT_A = 33;
    localparam int FIN_SHIFT_B = 29;
    localparam int FIN_SHIFT_C = 32;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // one classified request
    typedef struct packed {
        logic [WORD_W-1:0] word;    // masked to its valid bytes
        logic              mix;     // at least one valid byte
        logic              last;    // closes the message
        logic              first;   // opens the message, seed from length
        logic [LEN_W-1:0]  length;  // length register at arrival
    } t_cmd;

    function automatic logic [WORD_W-1:0] rotl_mix(input logic [WORD_W-1:0] v);
        rotl_mix = (v << ROT_AMT) | (v >> (WORD_W - ROT_AMT));
    endfunction

    function automatic logic [WORD_W-1:0] xsh(input logic [WORD_W-1:0] v,
                                              input int unsigned       amt);
        xsh = v ^ (v >> amt);
    endfunction

endpackage

### src/word_mix_hash_64.sv
// ----------------------------------------------------------------------------
// word_mix_hash_64
// streaming 64-bit multiply-rotate word hash with shift-xor-multiply finaliser
// ----------------------------------------------------------------------------
// Write the message length in bytes before the first request of a message; the
// length is sampled when that request is accepted on the input. Each request
// carries up to eight bytes, first byte lowest, with a byte count (counts above
// eight act as eight, zero mixes nothing); the request flagged tlast closes the
// message and yields one 64-bit digest, after which the next request opens a
// new message. All 64-bit products are built from three 32x32 partial products
// on a single shared multiplier, and that multiplier sets the rate: a request
// with bytes runs a word product and then an accumulator product, an empty
// non-last request runs none, and the closing request adds two finalisation
// products before the digest is loaded into the output register.
// A two-entry queue lets requests be accepted while the engine is busy and the
// digest sits in an output register until taken.
// ----------------------------------------------------------------------------
module word_mix_hash_64 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: message length in bytes
    input  logic        i_cfg_wen,
    input  logic [31:0] i_cfg_wdata,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [63:0] data_word, [67:64] byte_count, rest zero
    input  logic        s_axis_tlast,   // last_word
    // digest stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] digest
);
    import wmh_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic front_push;
    logic queue_full;
    logic queue_valid;
    logic back_pop;

    // front: length register, byte masking, start-of-message tracking
    wmh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_word      (s_axis_tdata[63:0]),
        .i_count     (s_axis_tdata[67:64]),
        .i_last      (s_axis_tlast),
        .i_q_full    (queue_full),
        .o_push      (front_push),
        .o_cmd       (front_cmd)
    );

    // decoupling queue
    wmh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    // back: mixing, finalising and digest output register
    wmh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_pop       (back_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata)
    );

endmodule

### src/wmh_front.sv
// ----------------------------------------------------------------------------
// wmh_front
// accepts requests, masks partial words, tracks message start, holds length
// ----------------------------------------------------------------------------
module wmh_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [31:0]           i_cfg_wdata,
    input  logic                  i_tvalid,
    output logic                  o_tready,
    input  logic [63:0]           i_word,
    input  logic [3:0]            i_count,
    input  logic                  i_last,
    input  logic                  i_q_full,
    output logic                  o_push,
    output wmh_pkg::t_cmd         o_cmd
);
    import wmh_pkg::*;

    logic [LEN_W-1:0]   r_msg_len;
    logic               r_first;
    logic [COUNT_W-1:0] cnt_sat;
    logic [WORD_W-1:0]  word_masked;

    assign o_tready = !i_q_full;
    assign o_push   = i_tvalid && !i_q_full;

    // counts above a full word saturate
    assign cnt_sat = (i_count > COUNT_W'(BYTES)) ? COUNT_W'(BYTES) : i_count;

    always_comb begin
        for (int i = 0; i < BYTES; i++) begin
            word_masked[i*8 +: 8] = (COUNT_W'(i) < cnt_sat) ? i_word[i*8 +: 8] : 8'h00;
        end
    end

    always_comb begin
        o_cmd.word   = word_masked;
        o_cmd.mix    = (cnt_sat != '0);
        o_cmd.last   = i_last;
        o_cmd.first  = r_first;
        o_cmd.length = r_msg_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_len <= '0;
            r_first   <= 1'b1;
        end else begin
            if (i_cfg_wen) begin
                r_msg_len <= i_cfg_wdata;
            end
            if (o_push) begin
                r_first <= i_last;
            end
        end
    end

endmodule

### src/wmh_queue.sv
// ----------------------------------------------------------------------------
// wmh_queue
// short command queue decoupling front and back
// ----------------------------------------------------------------------------
module wmh_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wmh_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output wmh_pkg::t_cmd o_cmd
);
    import wmh_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_pop;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
        ptr_inc = (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/wmh_back.sv
// ----------------------------------------------------------------------------
// wmh_back
// mixing and finalising sequencer around one shared 32x32 multiplier
// ----------------------------------------------------------------------------
module wmh_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  wmh_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_tvalid,
    input  logic          i_tready,
    output logic [63:0]   o_tdata
);
    import wmh_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MIX_W = 6'b000010,
        ST_MIX_A = 6'b000100,
        ST_FIN_A = 6'b001000,
        ST_FIN_B = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [1:0]         r_step, n_step;
    logic [WORD_W-1:0]  r_acc, n_acc;
    logic [WORD_W-1:0]  r_mul_a, n_mul_a;
    logic [WORD_W-1:0]  r_mul_b, n_mul_b;
    logic [WORD_W-1:0]  r_prod, n_prod;
    logic [WORD_W-1:0]  r_pp, n_pp;
    logic               r_last, n_last;
    logic               r_out_valid, n_out_valid;
    logic [WORD_W-1:0]  r_out_data, n_out_data;

    logic [HALF_W-1:0]  mul_x, mul_y;
    logic [WORD_W-1:0]  prod_done;
    logic [WORD_W-1:0]  acc_in;
    logic               mul_busy;
    logic               mul_last;

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;

    // partial products: lo*lo, hi*lo, lo*hi; the high cross terms fall off
    always_comb begin
        case (r_step)
            2'd0:    begin mul_x = r_mul_a[HALF_W-1:0];      mul_y = r_mul_b[HALF_W-1:0];      end
            2'd1:    begin mul_x = r_mul_a[WORD_W-1:HALF_W]; mul_y = r_mul_b[HALF_W-1:0];      end
            2'd2:    begin mul_x = r_mul_a[HALF_W-1:0];      mul_y = r_mul_b[WORD_W-1:HALF_W]; end
            default: begin mul_x = '0;                       mul_y = '0;                       end
        endcase
    end

    assign n_pp      = WORD_W'(mul_x) * WORD_W'(mul_y);
    assign prod_done = r_prod + {r_pp[HALF_W-1:0], {HALF_W{1'b0}}};
    assign acc_in    = i_cmd.first ? (HASH_K1 ^ {{(WORD_W-LEN_W){1'b0}}, i_cmd.length})
                                   : r_acc;
    assign mul_busy  = (r_state == ST_MIX_W) || (r_state == ST_MIX_A)
                    || (r_state == ST_FIN_A) || (r_state == ST_FIN_B);
    assign mul_last  = mul_busy && (r_step == 2'd3);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_acc       = r_acc;
        n_mul_a     = r_mul_a;
        n_mul_b     = r_mul_b;
        n_prod      = r_prod;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;

        if (r_out_valid && i_tready) begin
            n_out_valid = 1'b0;
        end

        // product accumulation while a multiply runs
        if (mul_busy) begin
            n_step = r_step + 2'd1;
            case (r_step)
                2'd1:    n_prod = r_prod + r_pp;
                2'd2:    n_prod = {r_prod[WORD_W-1:HALF_W] + r_pp[HALF_W-1:0],
                                   r_prod[HALF_W-1:0]};
                default: n_prod = r_prod;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop  = 1'b1;
                    n_last = i_cmd.last;
                    n_acc  = acc_in;
                    n_step = 2'd0;
                    n_prod = '0;
                    if (i_cmd.mix) begin
                        n_mul_a = i_cmd.word;
                        n_mul_b = HASH_K1;
                        n_state = ST_MIX_W;
                    end else if (i_cmd.last) begin
                        n_mul_a = xsh(acc_in, FIN_SHIFT_A);
                        n_mul_b = HASH_K1;
                        n_state = ST_FIN_A;
                    end
                end
            end
            ST_MIX_W: begin
                if (mul_last) begin
                    n_mul_a = rotl_mix(r_acc ^ prod_done);
                    n_mul_b = HASH_K2;
                    n_prod  = HASH_K3;  // bias folds in the additive constant
                    n_step  = 2'd0;
                    n_state = ST_MIX_A;
                end
            end
            ST_MIX_A: begin
                if (mul_last) begin
                    n_acc  = prod_done;
                    n_step = 2'd0;
                    if (r_last) begin
                        n_mul_a = xsh(prod_done, FIN_SHIFT_A);
                        n_mul_b = HASH_K1;
                        n_prod  = '0;
                        n_state = ST_FIN_A;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FIN_A: begin
                if (mul_last) begin
                    n_mul_a = xsh(prod_done, FIN_SHIFT_B);
                    n_mul_b = HASH_K2;
                    n_prod  = '0;
                    n_step  = 2'd0;
                    n_state = ST_FIN_B;
                end
            end
            ST_FIN_B: begin
                if (mul_last) begin
                    n_acc   = xsh(prod_done, FIN_SHIFT_C);
                    n_step  = 2'd0;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_acc;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mul_a    <= n_mul_a;
        r_mul_b    <= n_mul_b;
        r_prod     <= n_prod;
        r_pp       <= n_pp;
        r_out_data <= n_out_data;
        r_last     <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= 2'd0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### src/wmh_checker.sv
// ----------------------------------------------------------------------------
// wmh_checker
// port-level checks of the word mix hash engine, bound to the top level
// ----------------------------------------------------------------------------
module wmh_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata
);
    // messages closed on the input but whose digest is not yet taken
    logic [3:0] r_pending;
    logic       last_in;
    logic       dig_out;

    assign last_in = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign dig_out = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 4'd0;
        end else begin
            r_pending <= r_pending + {3'd0, last_in} - {3'd0, dig_out};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("digest dropped or changed while stalled");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != 4'd0)
        else $error("digest without a closed message");

    a_rst_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("digest valid straight after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> s_axis_tready)
        else $error("not ready straight after reset");

endmodule

bind word_mix_hash_64 wmh_checker u_wmh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/wmh_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wmh_scoreboard
// watches the length port and both streams, predicts every digest and compares
// ----------------------------------------------------------------------------
module wmh_scoreboard
    import wmh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wen,
    input  logic [LEN_W-1:0]  i_cfg_wdata,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  logic [71:0]       i_req_data,   // [63:0] data_word, [67:64] byte_count
    input  logic              i_req_last,   // last_word
    input  logic              i_dig_valid,
    input  logic              i_dig_ready,
    input  logic [WORD_W-1:0] i_dig_data,   // [63:0] digest
    input  logic              i_end_check,
    output int                o_pending,
    output int                o_fail_count
);

    logic [LEN_W-1:0]  msg_length;
    logic [WORD_W-1:0] running_hash;
    logic              at_msg_start;
    logic [WORD_W-1:0] digest_q[$];
    int                fail_total = 0;
    bit                end_seen   = 1'b0;

    // one word folded into the running hash
    function automatic logic [WORD_W-1:0] fold_word(input logic [WORD_W-1:0] h,
                                                    input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] t;
        t = h ^ (w * HASH_K1);
        t = {t[WORD_W-1-ROT_AMT:0], t[WORD_W-1:WORD_W-ROT_AMT]};
        return t * HASH_K2 + HASH_K3;
    endfunction

    function automatic logic [WORD_W-1:0] seal_hash(input logic [WORD_W-1:0] h);
        logic [WORD_W-1:0] t;
        t = h ^ (h >> FIN_SHIFT_A);
        t = t * HASH_K1;
        t = t ^ (t >> FIN_SHIFT_B);
        t = t * HASH_K2;
        return t ^ (t >> FIN_SHIFT_C);
    endfunction

    always @(posedge i_clk) begin
        logic [COUNT_W-1:0] nbytes;
        logic [WORD_W-1:0]  word;
        logic [WORD_W-1:0]  want;
        if (!i_rst_n) begin
            msg_length   = '0;
            running_hash = '0;
            at_msg_start = 1'b1;
            digest_q.delete();
        end else begin
            // digests first: one leaving now belongs to an older request
            if (i_dig_valid && i_dig_ready) begin
                if (digest_q.size() == 0) begin
                    $error("digest: expected none, actual %h", i_dig_data);
                    fail_total++;
                end else begin
                    want = digest_q.pop_front();
                    if (i_dig_data !== want) begin
                        $error("digest: expected %h, actual %h", want, i_dig_data);
                        fail_total++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                word   = i_req_data[WORD_W-1:0];
                nbytes = i_req_data[WORD_W+COUNT_W-1:WORD_W];
                if (nbytes > BYTES)
                    nbytes = COUNT_W'(BYTES);
                if (at_msg_start) begin
                    running_hash = HASH_K1 ^ {{(WORD_W-LEN_W){1'b0}}, msg_length};
                    at_msg_start = 1'b0;
                end
                if (nbytes != 0) begin
                    if (nbytes < BYTES)
                        word = word & ~({WORD_W{1'b1}} << (8 * nbytes));
                    running_hash = fold_word(running_hash, word);
                end
                if (i_req_last) begin
                    digest_q.push_back(seal_hash(running_hash));
                    at_msg_start = 1'b1;
                end
            end
            // a write lands after any request of the same edge
            if (i_cfg_wen)
                msg_length = i_cfg_wdata;
            if (i_end_check && !end_seen) begin
                end_seen = 1'b1;
                if (digest_q.size() != 0) begin
                    $error("digest: expected %0d more, actual none", digest_q.size());
                    fail_total += digest_q.size();
                end
            end
        end
        o_pending    <= digest_q.size();
        o_fail_count <= fail_total;
    end

endmodule

### tb/sv/tb_word_mix_hash_64.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_word_mix_hash_64
// directed and random regression of the streaming word hash engine
// ----------------------------------------------------------------------------
// Drives message requests and length writes into the engine and takes its
// digests with random gaps on both sides; a checker beside the engine predicts
// every digest and counts mismatches. Length writes happen only once the
// engine has drained, some of them in the middle of a message.
// ----------------------------------------------------------------------------
module tb_word_mix_hash_64;
    import wmh_pkg::*;

    localparam int HALF_PERIOD     = 6;       // 12 ns clock
    localparam int RESET_CYCLES    = 11;
    localparam int MAX_GAP         = 12;
    localparam int DRAIN_CYCLES    = 64;      // queue of two plus engine
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PRESSURE_MSGS   = 12;
    localparam int TOTAL_ITEMS     = 450;
    localparam int TIMEOUT_NS      = 3_000_000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_wen;
    logic [LEN_W-1:0]  i_cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [71:0]       s_axis_tdata;   // [63:0] data_word, [67:64] byte_count, rest zero
    logic              s_axis_tlast;   // last_word
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [63:0]       m_axis_tdata;   // [63:0] digest

    int  pending_digests;
    int  fail_count;
    logic end_check;

    // stimulus bookkeeping, only for the summary
    int  req_count  = 0;
    int  msg_count  = 0;
    int  cfg_count  = 0;
    int  hold_count = 0;

    // per-phase gap control; the sender raises the hold-off flag, the
    // receiver clears it once it has started holding
    bit  send_steady  = 1'b0;
    bit  take_steady  = 1'b0;
    bit  hold_off_req = 1'b0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    word_mix_hash_64 i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    wmh_scoreboard u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_last   (s_axis_tlast),
        .i_dig_valid  (m_axis_tvalid),
        .i_dig_ready  (m_axis_tready),
        .i_dig_data   (m_axis_tdata),
        .i_end_check  (end_check),
        .o_pending    (pending_digests),
        .o_fail_count (fail_count)
    );

    // ------------------------------------------------------------------------
    // sender side helpers, all entered and left at a falling edge
    // ------------------------------------------------------------------------

    // offer one request after a random gap and wait until it is taken
    task automatic send_request(input logic [WORD_W-1:0]  word,
                                input logic [COUNT_W-1:0] nbytes,
                                input logic               last);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {4'b0000, nbytes, word};
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge i_clk);
        req_count++;
        if (last)
            msg_count++;
    endtask

    // stop offering, wait for every digest, then give the engine time to
    // finish requests that produce no digest
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_digests != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // single-cycle length write, only ever called on a drained engine
    task automatic write_length(input logic [LEN_W-1:0] len);
        i_cfg_wdata <= len;
        i_cfg_wen   <= 1'b1;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
        cfg_count++;
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 64);
            default: return $urandom;
        endcase
    endfunction

    // mostly well-formed messages (full words, one closing partial word);
    // the rest is noise with any byte count, saturating ones included
    task automatic send_random_message();
        int              nwords;
        bit              tidy;
        bit              fin;
        logic [COUNT_W-1:0] nbytes;
        tidy   = ($urandom_range(0, 99) < 85);
        nwords = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
        for (int k = 0; k < nwords; k++) begin
            fin = (k == nwords - 1);
            if (tidy)
                nbytes = fin ? COUNT_W'($urandom_range(0, BYTES)) : COUNT_W'(BYTES);
            else
                nbytes = COUNT_W'($urandom_range(0, 15));
            // now and then change the length halfway through a message
            if (k != 0 && $urandom_range(0, 24) == 0) begin
                settle();
                write_length(pick_length());
            end
            send_request({$urandom, $urandom}, nbytes, fin);
        end
    endtask

    // ------------------------------------------------------------------------
    // digest receiver: random stalls, steady phases and one long hold-off
    // ------------------------------------------------------------------------
    initial begin : p_take
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                // counted here so the sender keeps filling the engine
                for (int k = 0; k < HOLD_OFF_CYCLES; k++) @(negedge i_clk);
                hold_count++;
            end else begin
                gap = take_steady ? 0 : $urandom_range(0, MAX_GAP);
                if (gap != 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // main stimulus
    // ------------------------------------------------------------------------
    initial begin : p_main
        int phase_msgs;
        phase_msgs    = 0;
        i_rst_n       = 1'b0;
        i_cfg_wen     = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        end_check     = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty message: a lone empty closing request digests the seed only
        write_length('0);
        send_request({$urandom, $urandom}, 4'd0, 1'b1);

        // longest length with an all-ones word, then an all-zero word
        settle();
        write_length('1);
        send_request('1, 4'd8, 1'b1);
        send_request('0, 4'd8, 1'b1);

        // empty and partial requests in the middle of a message
        settle();
        write_length(32'h0000_0017);
        send_request({$urandom, $urandom}, 4'd8, 1'b0);
        send_request({$urandom, $urandom}, 4'd0, 1'b0);
        send_request({$urandom, $urandom}, 4'd3, 1'b0);
        send_request({$urandom, $urandom}, 4'd5, 1'b1);

        // byte counts above eight act as eight
        for (int c = 9; c <= 15; c++)
            send_request({$urandom, $urandom}, COUNT_W'(c), c == 15);

        // every short closing word, bytes above the count are garbage
        for (int c = 1; c < BYTES; c++)
            send_request({$urandom, $urandom}, COUNT_W'(c), 1'b1);

        // length written halfway: only the next message sees it
        send_request(64'h5555_5555_5555_5555, 4'd8, 1'b0);
        settle();
        write_length(32'haaaa_aaaa);
        send_request(64'haaaa_aaaa_aaaa_aaaa, 4'd8, 1'b1);
        send_request({$urandom, $urandom}, 4'd2, 1'b1);

        // back pressure: the receiver holds off while requests keep coming
        settle();
        send_steady  = 1'b1;
        take_steady  = 1'b0;
        hold_off_req = 1'b1;
        for (int k = 0; k < PRESSURE_MSGS; k++)
            send_request({$urandom, $urandom}, COUNT_W'($urandom_range(1, BYTES)), 1'b1);

        // random phases, each with its own length and gap behaviour
        while (req_count < TOTAL_ITEMS) begin
            if (phase_msgs == 0) begin
                settle();
                send_steady = ($urandom_range(0, 3) == 0);
                take_steady = ($urandom_range(0, 3) == 0);
                write_length(pick_length());
                phase_msgs = $urandom_range(3, 10);
            end
            send_random_message();
            phase_msgs--;
        end

        // drain, then let the checker look for leftovers
        settle();
        end_check <= 1'b1;
        @(negedge i_clk);
        @(negedge i_clk);
        $display("covered %0d requests in %0d messages with %0d length writes",
                 req_count, msg_count, cfg_count);
        $display("digest side held off %0d time(s) for %0d cycles under full input",
                 hold_count, HOLD_OFF_CYCLES);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial begin : p_watchdog
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
